@@ hdl/dpte_pkg.sv @@
// shared types and constants of the demand paging table engine
package dpte_pkg;

  localparam int FRAME_W   = 20;
  localparam int ENTRY_W   = 32;
  localparam int REG_W     = 12;
  localparam int PIDX_W    = 12;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MARK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNMAP = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FAULT = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNALLOC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PROT      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OD_MASK   = 1'd1;

  localparam logic [REG_W-1:0] PROT_MASK_RST = 12'hFFE;
  localparam logic [REG_W-1:0] OD_MASK_RST   = 12'h200;

  // one input item
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PIDX_W-1:0]  page_index;
    logic [FRAME_W-1:0] frame_number;
    logic [REG_W-1:0]   prot_flags;
    logic               map_physical;
    logic               no_release;
    logic               fault_on_present;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [FRAME_W-1:0]  alloc_frame;
    logic [STATUS_W-1:0] status;
    logic                invalidate;
    logic [ENTRY_W-1:0]  entry_value;
  } out_item_t;

  // frame stack update for one item
  typedef struct packed {
    logic               pop;
    logic               push;
    logic [FRAME_W-1:0] frame;
  } stk_cmd_t;

  // frame stack status
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

@@ hdl/dpte_page_table.sv @@
// page table memory with clearing sweep after reset
module dpte_page_table #(
  parameter int ENTRIES = 4096,
  parameter int PAW     = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [PAW-1:0]              rd_addr,
  output logic [dpte_pkg::ENTRY_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [PAW-1:0]              wr_addr,
  input  logic [dpte_pkg::ENTRY_W-1:0] wr_data,
  output logic                        ready
);

  logic [dpte_pkg::ENTRY_W-1:0] mem [ENTRIES];
  logic [dpte_pkg::ENTRY_W-1:0] rd_data_r;
  logic                         clr_busy_r;
  logic [PAW-1:0]               clr_idx_r;
  logic                         mem_we;
  logic [PAW-1:0]               mem_wa;
  logic [dpte_pkg::ENTRY_W-1:0] mem_wd;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == PAW'(ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // sweep takes the write port while it runs
  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clr_busy_r;

endmodule

@@ hdl/dpte_frame_stack.sv @@
// free frame stack: memory plus fill count
module dpte_frame_stack #(
  parameter int FRAMES = 4096,
  parameter int FAW    = 12,
  parameter int CW     = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  dpte_pkg::stk_cmd_t          cmd,
  output logic [dpte_pkg::FRAME_W-1:0] top_frame,
  output dpte_pkg::stk_stat_t         stat,
  output logic [CW-1:0]               count
);

  logic [dpte_pkg::FRAME_W-1:0] mem [FRAMES];
  logic [dpte_pkg::FRAME_W-1:0] top_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                cnt_dec;

  assign cnt_dec = cnt_r - 1'b1;

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.pop) begin
      cnt_r <= cnt_dec;
    end else if (cmd.push) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // push writes the slot above the top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[FAW-1:0]] <= cmd.frame;
    end
  end

  // top of stack read, in the cycle before the pop
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r <= mem[cnt_dec[FAW-1:0]];
    end
  end

  assign top_frame  = top_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(FRAMES));
  assign count      = cnt_r;

endmodule

@@ hdl/demand_paging_table_engine.sv @@
// top level of the demand paging table engine
//
// Each item passes S_IDLE, where on acceptance the quotient estimate of the page
// index is registered, S_READ, which completes the reduction and reads the page
// entry and the free frame stack top from their synchronous memories, and S_EXEC,
// which modifies and writes back. The result strobe out_valid is high for one
// cycle after that, and busy is already low in that cycle, so a new item can
// start alongside it, but not before. The receiver cannot hold results off.
// After reset busy stays high while the page table is cleared; configuration
// writes are taken at any time, but should be made only while the block is idle.
module demand_paging_table_engine #(
  parameter int PAGES  = 4096,
  parameter int FRAMES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dpte_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output dpte_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [dpte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpte_pkg::REG_W-1:0]      cfg_wdata
);

  localparam int ENTRIES = (PAGES < 4096) ? PAGES : 4096;
  localparam int PAW     = $clog2(ENTRIES);
  localparam int FAW     = $clog2(FRAMES);
  localparam int CW      = $clog2(FRAMES + 1);
  localparam int RECIP_SH = 24;
  localparam logic [20:0] RECIP   = 21'((64'd1 << RECIP_SH) / PAGES);
  localparam logic [12:0] MODULUS = 13'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  dpte_pkg::out_item_t           out_data_r;
  dpte_pkg::out_item_t           out_nxt;
  dpte_pkg::in_item_t            item_r;
  logic [7:0]                    quot_r;
  logic [PAW-1:0]                page_r;
  logic [dpte_pkg::REG_W-1:0]    prot_mask_r;
  logic [dpte_pkg::REG_W-1:0]    od_mask_r;

  logic                          accept;
  logic                          pt_ready;
  logic [dpte_pkg::ENTRY_W-1:0]  pt_rd_data;
  logic                          pt_we;
  logic [dpte_pkg::ENTRY_W-1:0]  entry_nxt;
  logic [32:0]                   idx_prod;
  logic [20:0]                   quot_prod;
  logic [12:0]                   rem0;
  logic [12:0]                   rem1;
  logic [PAW-1:0]                page_rd;
  logic [dpte_pkg::FRAME_W-1:0]  top_frame;
  dpte_pkg::stk_cmd_t            stk_cmd;
  dpte_pkg::stk_stat_t           stk_stat;
  logic [CW-1:0]                 stk_count;
  logic [dpte_pkg::ENTRY_W-1:0]  entry;
  logic [dpte_pkg::REG_W-1:0]    prot;
  logic [dpte_pkg::FRAME_W-1:0]  old_frame;

  assign busy   = (state_r != S_IDLE) || !pt_ready;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_mask_r <= dpte_pkg::PROT_MASK_RST;
      od_mask_r   <= dpte_pkg::OD_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpte_pkg::CFG_PROT_MASK: prot_mask_r <= cfg_wdata;
        dpte_pkg::CFG_OD_MASK:   od_mask_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // page index modulo table depth: reciprocal estimate, then one correction
  assign idx_prod  = 33'(in_data.page_index) * 33'(RECIP);
  assign quot_prod = 21'(quot_r) * 21'(MODULUS);
  assign rem0      = {1'b0, item_r.page_index} - quot_prod[12:0];
  assign rem1      = (rem0 >= MODULUS) ? (rem0 - MODULUS) : rem0;
  assign page_rd   = rem1[PAW-1:0];

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            quot_r  <= idx_prod[RECIP_SH +: 8];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          page_r  <= page_rd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_data_r  <= out_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // modify step of the read-modify-write
  assign entry     = pt_rd_data;
  assign prot      = item_r.prot_flags & prot_mask_r;
  assign old_frame = entry[dpte_pkg::ENTRY_W-1:dpte_pkg::REG_W];

  always_comb begin
    out_nxt   = '0;
    entry_nxt = entry;
    pt_we     = 1'b0;
    stk_cmd   = '0;
    unique case (item_r.func)
      dpte_pkg::FN_ALLOC: begin
        if (stk_stat.empty) begin
          out_nxt.status = dpte_pkg::ST_EMPTY;
        end else begin
          stk_cmd.pop         = 1'b1;
          out_nxt.alloc_frame = top_frame;
        end
      end
      dpte_pkg::FN_FREE: begin
        if (stk_stat.full) begin
          out_nxt.status = dpte_pkg::ST_OVERFLOW;
        end else begin
          stk_cmd.push  = 1'b1;
          stk_cmd.frame = item_r.frame_number;
        end
      end
      dpte_pkg::FN_MARK: begin
        pt_we = 1'b1;
        if (!entry[0]) begin
          if (!item_r.map_physical) begin
            entry_nxt = {20'd0, od_mask_r | prot};
          end else begin
            entry_nxt          = {item_r.frame_number, prot | 12'd1};
            out_nxt.invalidate = 1'b1;
          end
        end else if (!item_r.map_physical) begin
          entry_nxt = (entry & ~{20'd0, prot_mask_r}) | {20'd0, prot};
        end else begin
          out_nxt.status = dpte_pkg::ST_CONFLICT;
        end
        out_nxt.entry_value = entry_nxt;
      end
      dpte_pkg::FN_UNMAP: begin
        pt_we               = 1'b1;
        entry_nxt           = '0;
        out_nxt.entry_value = entry;
        if (entry[0]) begin
          out_nxt.invalidate = 1'b1;
          if (!item_r.no_release && (old_frame != '0)) begin
            if (stk_stat.full) begin
              out_nxt.status = dpte_pkg::ST_OVERFLOW;
            end else begin
              stk_cmd.push  = 1'b1;
              stk_cmd.frame = old_frame;
            end
          end
        end
      end
      dpte_pkg::FN_FAULT: begin
        if (item_r.fault_on_present) begin
          out_nxt.status = dpte_pkg::ST_PROT;
        end else if ((entry[dpte_pkg::REG_W-1:0] & od_mask_r) == '0) begin
          out_nxt.status = dpte_pkg::ST_UNALLOC;
        end else if (stk_stat.empty) begin
          out_nxt.status = dpte_pkg::ST_EMPTY;
        end else begin
          stk_cmd.pop         = 1'b1;
          pt_we               = 1'b1;
          entry_nxt           = {top_frame,
                                 (entry[dpte_pkg::REG_W-1:0] & prot_mask_r) | 12'd1};
          out_nxt.alloc_frame = top_frame;
          out_nxt.invalidate  = 1'b1;
        end
        out_nxt.entry_value = entry_nxt;
      end
      default: ;
    endcase
    // updates take effect only in the write-back cycle
    if (state_r != S_EXEC) begin
      pt_we   = 1'b0;
      stk_cmd = '0;
    end
  end

  dpte_page_table #(
    .ENTRIES (ENTRIES),
    .PAW     (PAW)
  ) u_page_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == S_READ),
    .rd_addr (page_rd),
    .rd_data (pt_rd_data),
    .wr_en   (pt_we),
    .wr_addr (page_r),
    .wr_data (entry_nxt),
    .ready   (pt_ready)
  );

  dpte_frame_stack #(
    .FRAMES (FRAMES),
    .FAW    (FAW),
    .CW     (CW)
  ) u_frame_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (state_r == S_READ),
    .cmd       (stk_cmd),
    .top_frame (top_frame),
    .stat      (stk_stat),
    .count     (stk_count)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a result follows only a write-back cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result without write-back");

  // one item at a time, so results never come back to back
  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("results back to back");

  // the stack never pops when empty and never exceeds its depth
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.pop |-> !stk_stat.empty)
    else $error("pop of empty frame stack");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_count <= CW'(FRAMES))
    else $error("frame stack count beyond depth");
`endif

endmodule

@@ verif/page_table_mirror_pkg.sv @@
// mirror of the page table engine state that predicts and checks its results
package page_table_mirror_pkg;
  import dpte_pkg::*;

  localparam int TBL_PAGES  = 4096;
  localparam int TBL_FRAMES = 4096;
  localparam logic [REG_W-1:0] PRESENT_FLAG = 12'h001;
  localparam int unsigned REPORT_LIMIT = 10;

  class page_table_mirror;
    logic [ENTRY_W-1:0] entries [TBL_PAGES];
    logic [FRAME_W-1:0] frame_stack [TBL_FRAMES];
    int unsigned depth;
    logic [REG_W-1:0] prot_mask;
    logic [REG_W-1:0] od_mask;
    out_item_t due [$];
    int unsigned fails;
    int unsigned seen;

    function new();
      foreach (entries[i]) entries[i] = '0;
      depth = 0;
      prot_mask = PROT_MASK_RST;
      od_mask = OD_MASK_RST;
      fails = 0;
      seen = 0;
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_PROT_MASK: prot_mask = val;
        CFG_OD_MASK:   od_mask = val;
        default: ;
      endcase
    endfunction

    // free frame stack
    function bit pop_frame(output logic [FRAME_W-1:0] fr);
      if (depth == 0) begin
        fr = '0;
        return 1'b0;
      end
      depth--;
      fr = frame_stack[depth];
      return 1'b1;
    endfunction

    function bit push_frame(logic [FRAME_W-1:0] fr);
      if (depth >= TBL_FRAMES) return 1'b0;
      frame_stack[depth] = fr;
      depth++;
      return 1'b1;
    endfunction

    // work out the result of one accepted item and update the mirrored state
    function void note_item(in_item_t it);
      out_item_t res;
      logic [ENTRY_W-1:0] ent;
      logic [FRAME_W-1:0] fr;
      logic [REG_W-1:0] prot;
      res = '0;
      fr = '0;
      ent = entries[it.page_index];
      prot = it.prot_flags & prot_mask;
      case (it.func)
        FN_ALLOC: begin
          if (!pop_frame(fr)) res.status = ST_EMPTY;
          res.alloc_frame = fr;
        end
        FN_FREE: begin
          if (!push_frame(it.frame_number)) res.status = ST_OVERFLOW;
        end
        FN_MARK: begin
          // bit 0 of an entry is the present bit
          if (!ent[0]) begin
            if (it.map_physical) begin
              ent = {it.frame_number, prot | PRESENT_FLAG};
              res.invalidate = 1'b1;
            end else begin
              ent = ENTRY_W'(od_mask | prot);
            end
          end else if (!it.map_physical) begin
            // protection change keeps the frame and the bits outside the mask
            ent = (ent & ~ENTRY_W'(prot_mask)) | ENTRY_W'(prot);
          end else begin
            res.status = ST_CONFLICT;
          end
          entries[it.page_index] = ent;
          res.entry_value = ent;
        end
        FN_UNMAP: begin
          entries[it.page_index] = '0;
          res.entry_value = ent;
          if (ent[0]) begin
            res.invalidate = 1'b1;
            fr = ent[ENTRY_W-1:REG_W];
            if (!it.no_release && fr != '0 && !push_frame(fr)) res.status = ST_OVERFLOW;
          end
        end
        FN_FAULT: begin
          if (it.fault_on_present) begin
            res.status = ST_PROT;
          end else if ((ent[REG_W-1:0] & od_mask) == '0) begin
            res.status = ST_UNALLOC;
          end else if (!pop_frame(fr)) begin
            res.status = ST_EMPTY;
          end else begin
            ent = {fr, (ent[REG_W-1:0] & prot_mask) | PRESENT_FLAG};
            entries[it.page_index] = ent;
            res.alloc_frame = fr;
            res.invalidate = 1'b1;
          end
          res.entry_value = ent;
        end
        default: ;
      endcase
      due.push_back(res);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      seen++;
      if (due.size() == 0) begin
        flag($sformatf("result %0d with nothing pending: frame %h status %0d inval %0d entry %h",
                       seen, got.alloc_frame, got.status, got.invalidate, got.entry_value));
        return;
      end
      want = due.pop_front();
      if (got.alloc_frame !== want.alloc_frame || got.status !== want.status ||
          got.invalidate !== want.invalidate || got.entry_value !== want.entry_value) begin
        flag($sformatf({"result %0d: frame %h status %0d inval %0d entry %h, ",
                        "expected frame %h status %0d inval %0d entry %h"},
                       seen, got.alloc_frame, got.status, got.invalidate, got.entry_value,
                       want.alloc_frame, want.status, want.invalidate, want.entry_value));
      end
    endfunction

    function int unsigned outstanding();
      return due.size();
    endfunction

    function void close_out();
      if (due.size() != 0) flag($sformatf("%0d results never arrived", due.size()));
    endfunction
  endclass

endpackage

@@ verif/tb_demand_paging_table_engine.sv @@
// testbench top of the demand paging table engine with directed and random items
module tb_demand_paging_table_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import dpte_pkg::*;
  import page_table_mirror_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned PHASES      = 6;
  // operation codes the block does not define
  localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  page_table_mirror mirror;
  int unsigned items_sent = 0;
  int unsigned calm_left = 0;
  int unsigned cycles = 0;

  demand_paging_table_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // observe results, accepted items and register writes at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) mirror.check_result(out_data);
      if (start && !busy) mirror.note_item(in_data);
      if (cfg_we) mirror.write_reg(cfg_index, cfg_wdata);
    end
  end

  function automatic logic rnd_bit();
    return 1'($urandom());
  endfunction

  function automatic logic [REG_W-1:0] rnd_prot();
    return REG_W'($urandom());
  endfunction

  // frames: mostly random, sometimes zero or all ones
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FRAME_W'($urandom());
  endfunction

  // pages: mostly a small working set at both ends of the table
  function automatic logic [PIDX_W-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return PIDX_W'($urandom_range(0, 7));
    if (r < 7) return PIDX_W'($urandom_range(4088, 4095));
    return PIDX_W'($urandom());
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.func = FUNC_W'($urandom_range(0, 7));
    it.page_index = PIDX_W'($urandom());
    it.frame_number = FRAME_W'($urandom());
    it.prot_flags = rnd_prot();
    it.map_physical = rnd_bit();
    it.no_release = rnd_bit();
    it.fault_on_present = rnd_bit();
    return it;
  endfunction

  // random gap after an item, with stretches of back-to-back items
  task automatic pause_inputs();
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) calm_left = $urandom_range(20, 80);
      else if (r < 55) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(13, 40);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // present an item and hold it until busy is seen low after an edge
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    pause_inputs();
  endtask

  task automatic issue_alloc();
    in_item_t it;
    it = noise_item();
    it.func = FN_ALLOC;
    send_item(it);
  endtask

  task automatic issue_free(input logic [FRAME_W-1:0] fr);
    in_item_t it;
    it = noise_item();
    it.func = FN_FREE;
    it.frame_number = fr;
    send_item(it);
  endtask

  task automatic issue_mark(input logic [PIDX_W-1:0] pg, input logic mp,
                            input logic [FRAME_W-1:0] fr, input logic [REG_W-1:0] pr);
    in_item_t it;
    it = noise_item();
    it.func = FN_MARK;
    it.page_index = pg;
    it.map_physical = mp;
    it.frame_number = fr;
    it.prot_flags = pr;
    send_item(it);
  endtask

  task automatic issue_unmap(input logic [PIDX_W-1:0] pg, input logic nr);
    in_item_t it;
    it = noise_item();
    it.func = FN_UNMAP;
    it.page_index = pg;
    it.no_release = nr;
    send_item(it);
  endtask

  task automatic issue_fault(input logic [PIDX_W-1:0] pg, input logic fp);
    in_item_t it;
    it = noise_item();
    it.func = FN_FAULT;
    it.page_index = pg;
    it.fault_on_present = fp;
    send_item(it);
  endtask

  // wait until every accepted item has produced its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  // write both registers on consecutive edges
  task automatic load_masks(input logic [REG_W-1:0] pm, input logic [REG_W-1:0] od);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PROT_MASK;
    cfg_wdata <= pm;
    @(posedge clk);
    cfg_index <= CFG_OD_MASK;
    cfg_wdata <= od;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // corner cases under the reset masks
  task automatic run_directed();
    in_item_t spare;
    issue_alloc();                               // empty pool
    issue_fault(12'd7, 1'b0);                    // no on-demand mark
    issue_mark(12'd0, 1'b0, 20'h0, 12'hFFF);     // on-demand with all flags
    issue_fault(12'd0, 1'b1);                    // protection violation
    issue_fault(12'd0, 1'b0);                    // fault with empty pool
    issue_free(20'hFFFFF);
    issue_free(20'h00000);
    issue_free(20'hABCDE);
    issue_fault(12'd0, 1'b0);                    // demand allocation
    issue_mark(12'd0, 1'b1, 20'h12345, 12'h0);   // map over a present page
    issue_mark(12'd0, 1'b0, 20'h0, 12'h000);     // protection change
    issue_unmap(12'd0, 1'b0);                    // frame back to the pool
    issue_mark(12'd4095, 1'b1, 20'hFFFFF, 12'hFFF);
    issue_unmap(12'd4095, 1'b1);                 // frame kept off the pool
    issue_mark(12'd5, 1'b1, 20'h00000, 12'h000);
    issue_unmap(12'd5, 1'b0);                    // zero frame never pushed
    issue_mark(12'd9, 1'b0, 20'h0, 12'h555);
    issue_unmap(12'd9, 1'b0);                    // not present, no invalidate
    repeat (4) issue_alloc();
    spare = '0;
    spare.func = FN_SPARE_5;
    send_item(spare);
    spare = noise_item();
    spare.func = FN_SPARE_6;
    send_item(spare);
    spare = '1;
    spare.func = FN_SPARE_7;
    send_item(spare);
  endtask

  // mostly well-formed page lifetimes with random content, some loose items
  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    logic [PIDX_W-1:0] pg;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pg = pick_page();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // on-demand page: mark, fault in, maybe reprotect, unmap
          if (rnd_bit()) issue_free(pick_frame());
          issue_mark(pg, 1'b0, pick_frame(), rnd_prot());
          if ($urandom_range(0, 3) == 0) issue_fault(pg, 1'b1);
          issue_fault(pg, 1'b0);
          if (rnd_bit()) issue_mark(pg, 1'b0, pick_frame(), rnd_prot());
          if ($urandom_range(0, 3) == 0) issue_fault(pg, 1'b0);
          issue_unmap(pg, $urandom_range(0, 4) == 0);
        end
        3, 4: begin
          // directly mapped page, with a conflicting map now and then
          issue_mark(pg, 1'b1, pick_frame(), rnd_prot());
          if ($urandom_range(0, 2) == 0) issue_mark(pg, 1'b1, pick_frame(), rnd_prot());
          if (rnd_bit()) issue_mark(pg, 1'b0, pick_frame(), rnd_prot());
          issue_unmap(pg, $urandom_range(0, 4) == 0);
        end
        5: issue_alloc();
        6: issue_free(pick_frame());
        7: send_item(noise_item());
        8: issue_fault(pg, rnd_bit());
        default: issue_unmap(pg, rnd_bit());
      endcase
    end
  endtask

  // main sequence
  initial begin
    mirror = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PROT_MASK;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    // one random phase per mask setting, extremes included
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_masks(12'h000, 12'h000);
        1: load_masks(12'hFFF, 12'hFFF);
        2: load_masks(REG_W'($urandom()), REG_W'($urandom()));
        3: load_masks(12'hFFF, 12'h001);
        4: load_masks(REG_W'($urandom()), REG_W'(1 << $urandom_range(0, REG_W - 1)));
        default: load_masks(PROT_MASK_RST, OD_MASK_RST);
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (4) @(posedge clk);

    mirror.close_out();
    if (mirror.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
